[rtl/core/hms_pkg.sv]
// shared types, codes and the mode transition function of the heater mode state machine
package hms_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned MODE_W      = 3;
   localparam int unsigned TEMP_W      = 10;
   localparam int unsigned MINUTES_W   = 8;
   localparam int unsigned CFGBITS_W   = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam int unsigned MINUTE_W    = 16;
   localparam int unsigned LIMIT_W     = MINUTES_W + MINUTE_W;

   localparam int unsigned HOLD_MS_DEFAULT = 500;
   localparam logic [MINUTE_W-1:0] MINUTE_MS = 16'd60000;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_INVALID = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TIPERR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SLEEP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STAND   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ON      = 3'd5;

   // event codes
   localparam logic [3:0] EV_CONFIG   = 4'd0;
   localparam logic [3:0] EV_PRESS    = 4'd1;
   localparam logic [3:0] EV_HELD     = 4'd2;
   localparam logic [3:0] EV_USER     = 4'd3;
   localparam logic [3:0] EV_TO_SLEEP = 4'd4;
   localparam logic [3:0] EV_TO_OFF   = 4'd5;
   localparam logic [3:0] EV_INSTAND  = 4'd6;
   localparam logic [3:0] EV_OUTSTAND = 4'd7;
   localparam logic [3:0] EV_TEMP_OK  = 4'd8;
   localparam logic [3:0] EV_TEMP_BAD = 4'd9;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP_TIMEOUT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_TIMEOUT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP_TEMP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAND_TEMP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIG_MASK   = 3'd4;

   typedef logic [MODE_W-1:0] mode_type;

   // events raised by one tick, in the order they are applied
   typedef struct packed {
      logic config_done;
      logic user_change;
      logic stand_change;
      logic press;
      logic held;
      logic to_sleep;
      logic to_off;
   } events_type;

   // fixed transition table; codes outside the six modes pass unchanged
   function automatic mode_type next_mode(input logic [3:0] ev, input mode_type m);
      mode_type r;
      r = m;
      case (ev)
         EV_CONFIG:   if (m == MODE_INVALID) r = MODE_OFF;
         EV_PRESS: begin
            if (m == MODE_SLEEP) r = MODE_ON;
            else if (m inside {MODE_STAND, MODE_ON}) r = MODE_SLEEP;
         end
         EV_HELD: begin
            if (m == MODE_OFF) r = MODE_ON;
            else if (m inside {MODE_SLEEP, MODE_STAND, MODE_ON}) r = MODE_OFF;
         end
         EV_USER:     if (m == MODE_SLEEP) r = MODE_ON;
         EV_TO_SLEEP: if (m inside {MODE_STAND, MODE_ON}) r = MODE_SLEEP;
         EV_TO_OFF:   if (m inside {MODE_SLEEP, MODE_STAND, MODE_ON}) r = MODE_OFF;
         EV_INSTAND:  if (m == MODE_ON) r = MODE_STAND;
         EV_OUTSTAND: if (m == MODE_STAND) r = MODE_ON;
         EV_TEMP_OK:  if (m == MODE_TIPERR) r = MODE_OFF;
         EV_TEMP_BAD: if (m inside {[MODE_TIPERR:MODE_ON]}) r = MODE_TIPERR;
         default:     r = m;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/heater_mode_state_machine.sv]
// top level of the heater mode state machine: handshake, state and result registers
//
// one control tick comes in on the req_ channel and yields exactly one result on
// the rsp_ channel: the heater mode, the target temperature it selects and a
// controller reset flag that is set when the tick changed the mode
// a transfer happens at a rising edge where valid is high and stall is low
// path: a transferred tick lands in the input register, is evaluated from there and
// is written to the result register, whose valid bit drives rsp_valid
// throughput: one tick per cycle while no waiting result is stalled; the update of the
// mode and timer state straight from the input register makes that rate possible
// when rsp_stall holds a waiting result, the input register keeps its tick and
// req_stall is raised until the result is taken; no tick is dropped
// reset (synchronous, active high) empties both registers, puts the mode into
// invalid config, clears timers and seen config bits and loads register defaults
// csr_ writes are taken at any edge with csr_write high and must only come while
// the block is idle; writes to indexes past the register list are ignored
module heater_mode_state_machine import hms_pkg::*; #(
   parameter int unsigned HOLD_MS = HOLD_MS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic                   req_press_edge,
   input  logic                   req_release_edge,
   input  logic                   req_tip_in_stand,
   input  logic                   req_temp_in_limits,
   input  logic [TEMP_W-1:0]      req_user_target,
   input  logic [CFGBITS_W-1:0]   req_config_bits,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [MODE_W-1:0]      rsp_mode,
   output logic [TEMP_W-1:0]      rsp_target_temperature,
   output logic                   rsp_controller_reset,
   // configuration write port
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // input register
   logic                 in_valid_ff;
   logic [TIME_W-1:0]    in_now_ff;
   logic                 in_press_ff;
   logic                 in_release_ff;
   logic                 in_stand_ff;
   logic                 in_temp_ok_ff;
   logic [TEMP_W-1:0]    in_user_ff;
   logic [CFGBITS_W-1:0] in_cfgbits_ff;

   // result register
   logic                 out_valid_ff;
   logic                 out_valid_in;
   mode_type             out_mode_ff;
   logic [TEMP_W-1:0]    out_target_ff;
   logic                 out_reset_ff;

   // machine state
   mode_type             mode_ff;
   logic [TIME_W-1:0]    last_action_ff;
   logic [TIME_W-1:0]    hold_deadline_ff;
   logic                 hold_armed_ff;
   logic                 prev_stand_ff;
   logic [TEMP_W-1:0]    prev_user_ff;
   logic [CFGBITS_W-1:0] config_seen_ff;

   // configuration registers; timeouts are kept as millisecond limits
   logic [LIMIT_W-1:0]   sleep_limit_ff;
   logic [LIMIT_W-1:0]   off_limit_ff;
   logic [TEMP_W-1:0]    sleep_temp_ff;
   logic [TEMP_W-1:0]    stand_temp_ff;
   logic [CFGBITS_W-1:0] config_mask_ff;
   logic [LIMIT_W-1:0]   limit_in;

   // tick evaluation
   events_type           events;
   logic [TIME_W-1:0]    last_action_in;
   logic [TIME_W-1:0]    hold_deadline_in;
   logic                 hold_armed_in;
   logic [CFGBITS_W-1:0] config_seen_in;
   mode_type             mode_in;
   logic [TEMP_W-1:0]    target_in;

   logic                 advance;
   logic                 req_take;

   // the input register moves on when the result register is free or being emptied
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   hms_event_gen #(
      .HOLD_MS (HOLD_MS)
   ) u_event_gen (
      .now_ms               (in_now_ff),
      .press_edge           (in_press_ff),
      .release_edge         (in_release_ff),
      .tip_in_stand         (in_stand_ff),
      .user_target          (in_user_ff),
      .config_bits          (in_cfgbits_ff),
      .last_action_ms       (last_action_ff),
      .hold_deadline_ms     (hold_deadline_ff),
      .hold_armed           (hold_armed_ff),
      .prev_in_stand        (prev_stand_ff),
      .prev_user_target     (prev_user_ff),
      .config_seen          (config_seen_ff),
      .config_complete_mask (config_mask_ff),
      .sleep_limit          (sleep_limit_ff),
      .off_limit            (off_limit_ff),
      .events               (events),
      .last_action_next     (last_action_in),
      .hold_deadline_next   (hold_deadline_in),
      .hold_armed_next      (hold_armed_in),
      .config_seen_next     (config_seen_in)
   );

   hms_mode_chain u_mode_chain (
      .mode_before    (mode_ff),
      .events         (events),
      .tip_in_stand   (in_stand_ff),
      .temp_in_limits (in_temp_ok_ff),
      .mode_after     (mode_in)
   );

   // setpoint selected by the new mode
   always_comb begin
      case (mode_in)
         MODE_SLEEP: target_in = sleep_temp_ff;
         MODE_STAND: target_in = stand_temp_ff;
         MODE_ON:    target_in = in_user_ff;
         default:    target_in = '0;
      endcase
   end

   // minutes to milliseconds at write time keeps the multiplier off the tick path
   assign limit_in = LIMIT_W'(csr_data[MINUTES_W-1:0]) * LIMIT_W'(MINUTE_MS);

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         mode_ff          <= MODE_INVALID;
         last_action_ff   <= '0;
         hold_deadline_ff <= '0;
         hold_armed_ff    <= 1'b0;
         prev_stand_ff    <= 1'b0;
         prev_user_ff     <= '0;
         config_seen_ff   <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_ff          <= mode_in;
            last_action_ff   <= last_action_in;
            hold_deadline_ff <= hold_deadline_in;
            hold_armed_ff    <= hold_armed_in;
            prev_stand_ff    <= in_stand_ff;
            prev_user_ff     <= in_user_ff;
            config_seen_ff   <= config_seen_in;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_limit_ff <= '0;
         off_limit_ff   <= '0;
         sleep_temp_ff  <= '0;
         stand_temp_ff  <= '0;
         config_mask_ff <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SLEEP_TIMEOUT: sleep_limit_ff <= limit_in;
            CSR_OFF_TIMEOUT:   off_limit_ff   <= limit_in;
            CSR_SLEEP_TEMP:    sleep_temp_ff  <= csr_data[TEMP_W-1:0];
            CSR_STAND_TEMP:    stand_temp_ff  <= csr_data[TEMP_W-1:0];
            CSR_CONFIG_MASK:   config_mask_ff <= csr_data[CFGBITS_W-1:0];
            default:           ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff     <= req_now_ms;
         in_press_ff   <= req_press_edge;
         in_release_ff <= req_release_edge;
         in_stand_ff   <= req_tip_in_stand;
         in_temp_ok_ff <= req_temp_in_limits;
         in_user_ff    <= req_user_target;
         in_cfgbits_ff <= req_config_bits;
      end
      if (advance) begin
         out_mode_ff   <= mode_in;
         out_target_ff <= target_in;
         out_reset_ff  <= (mode_in != mode_ff);
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_mode               = out_mode_ff;
   assign rsp_target_temperature = out_target_ff;
   assign rsp_controller_reset   = out_reset_ff;

endmodule

[rtl/core/hms_event_gen.sv]
// event detection and timer bookkeeping for one control tick
module hms_event_gen import hms_pkg::*; #(
   parameter int unsigned HOLD_MS = HOLD_MS_DEFAULT
) (
   input  logic [TIME_W-1:0]    now_ms,
   input  logic                 press_edge,
   input  logic                 release_edge,
   input  logic                 tip_in_stand,
   input  logic [TEMP_W-1:0]    user_target,
   input  logic [CFGBITS_W-1:0] config_bits,
   input  logic [TIME_W-1:0]    last_action_ms,
   input  logic [TIME_W-1:0]    hold_deadline_ms,
   input  logic                 hold_armed,
   input  logic                 prev_in_stand,
   input  logic [TEMP_W-1:0]    prev_user_target,
   input  logic [CFGBITS_W-1:0] config_seen,
   input  logic [CFGBITS_W-1:0] config_complete_mask,
   input  logic [LIMIT_W-1:0]   sleep_limit,
   input  logic [LIMIT_W-1:0]   off_limit,
   output events_type           events,
   output logic [TIME_W-1:0]    last_action_next,
   output logic [TIME_W-1:0]    hold_deadline_next,
   output logic                 hold_armed_next,
   output logic [CFGBITS_W-1:0] config_seen_next
);

   logic [CFGBITS_W-1:0] seen_or;
   logic                 user_activity;
   logic                 armed_mid;
   logic                 armed_after_release;
   logic [TIME_W-1:0]    hold_diff;
   logic [TIME_W-1:0]    elapsed;

   always_comb begin
      seen_or          = config_seen | config_bits;
      config_seen_next = (config_bits != '0) ? seen_or : config_seen;

      events.config_done  = (config_bits != '0) && (seen_or == config_complete_mask);
      events.user_change  = (user_target != prev_user_target);
      events.stand_change = (tip_in_stand != prev_in_stand);

      user_activity    = events.user_change | events.stand_change | press_edge | release_edge;
      last_action_next = user_activity ? now_ms : last_action_ms;

      // press arms the hold timer, release disarms it as a short press
      hold_deadline_next  = press_edge ? (now_ms + TIME_W'(HOLD_MS)) : hold_deadline_ms;
      armed_mid           = press_edge | hold_armed;
      events.press        = release_edge & armed_mid;
      armed_after_release = armed_mid & ~release_edge;

      // wrapping "past deadline" test
      hold_diff       = now_ms - hold_deadline_next;
      events.held     = armed_after_release && (hold_diff != '0) && !hold_diff[TIME_W-1];
      hold_armed_next = armed_after_release & ~events.held;

      elapsed         = now_ms - last_action_next;
      events.to_sleep = (sleep_limit != '0) && (elapsed > TIME_W'(sleep_limit));
      events.to_off   = (off_limit != '0) && (elapsed > TIME_W'(off_limit));
   end

endmodule

[rtl/core/hms_mode_chain.sv]
// applies the tick's event chain to the mode through the transition table
module hms_mode_chain import hms_pkg::*; (
   input  mode_type   mode_before,
   input  events_type events,
   input  logic       tip_in_stand,
   input  logic       temp_in_limits,
   output mode_type   mode_after
);

   mode_type m;

   always_comb begin
      m = mode_before;
      if (events.config_done)  m = next_mode(EV_CONFIG, m);
      if (events.user_change)  m = next_mode(EV_USER, m);
      if (events.stand_change) m = next_mode(EV_USER, m);
      if (events.press)        m = next_mode(EV_PRESS, m);
      if (events.held)         m = next_mode(EV_HELD, m);
      m = next_mode(tip_in_stand ? EV_INSTAND : EV_OUTSTAND, m);
      m = next_mode(temp_in_limits ? EV_TEMP_OK : EV_TEMP_BAD, m);
      if (events.to_sleep)     m = next_mode(EV_TO_SLEEP, m);
      if (events.to_off)       m = next_mode(EV_TO_OFF, m);
      mode_after = m;
   end

endmodule
